// ===== rtl/core/vfm_pkg.sv =====
// Shared constants for the two-dimensional viewing matrix block.
// Used by vfm_cell, view_frame_matrix_2d, vfm_checker and the testbench; depends on nothing.
package vfm_pkg;

   // Unit vector components are Q1.14.
   localparam int FRAC_BITS = 14;
   // Bits of the unit magnitude search (magnitude never exceeds 2^14).
   localparam int Q_BITS = 15;
   // Saturation limit of the translation terms.
   localparam int T_LIMIT = 46341;
   // Rotation and translation field widths.
   localparam int ROT_W = 16;
   localparam int TRN_W = 17;

endpackage

// ===== rtl/core/vfm_cell.sv =====
// One bit step of the unit magnitude search, for both components at once.
// Depends on vfm_pkg; chained Q_BITS times inside view_frame_matrix_2d.
module vfm_cell
   import vfm_pkg::*;
#(
   parameter int PW  = 66,
   parameter int SW  = 35,
   parameter int BIT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [PW-1:0] in_s,
   input  logic signed [PW-1:0] in_rx,
   input  logic signed [PW-1:0] in_ry,
   input  logic signed [PW-1:0] in_px,
   input  logic signed [PW-1:0] in_py,
   input  logic signed [PW-1:0] in_qx,
   input  logic signed [PW-1:0] in_qy,
   input  logic [Q_BITS-1:0]    in_mx,
   input  logic [Q_BITS-1:0]    in_my,
   input  logic [SW-1:0]        in_side,
   output logic                 out_valid,
   output logic signed [PW-1:0] out_s,
   output logic signed [PW-1:0] out_rx,
   output logic signed [PW-1:0] out_ry,
   output logic signed [PW-1:0] out_px,
   output logic signed [PW-1:0] out_py,
   output logic signed [PW-1:0] out_qx,
   output logic signed [PW-1:0] out_qy,
   output logic [Q_BITS-1:0]    out_mx,
   output logic [Q_BITS-1:0]    out_my,
   output logic [SW-1:0]        out_side
);

   // P holds (2m-1)^2*s and Q holds (2m-1)*s for the bits settled so far;
   // trying bit k adds 2^(k+2)*Q + 2^(2k+2)*s to P.
   logic signed [PW-1:0] step_s, cand_x, cand_y;
   logic signed [PW-1:0] qinc;
   logic                 ok_x, ok_y;
   logic                 valid_ff;
   logic signed [PW-1:0] s_ff, rx_ff, ry_ff, px_ff, py_ff, qx_ff, qy_ff;
   logic [Q_BITS-1:0]    mx_ff, my_ff;
   logic [SW-1:0]        side_ff;
   logic [Q_BITS-1:0]    bit_mask;

   assign bit_mask = Q_BITS'(1) << BIT;
   assign step_s   = in_s <<< (2 * BIT + 2);
   assign qinc     = in_s <<< (BIT + 1);
   assign cand_x   = in_px + (in_qx <<< (BIT + 2)) + step_s;
   assign cand_y   = in_py + (in_qy <<< (BIT + 2)) + step_s;
   assign ok_x     = cand_x <= in_rx;
   assign ok_y     = cand_y <= in_ry;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= in_s;
         rx_ff   <= in_rx;
         ry_ff   <= in_ry;
         px_ff   <= ok_x ? cand_x : in_px;
         py_ff   <= ok_y ? cand_y : in_py;
         qx_ff   <= ok_x ? in_qx + qinc : in_qx;
         qy_ff   <= ok_y ? in_qy + qinc : in_qy;
         mx_ff   <= ok_x ? (in_mx | bit_mask) : in_mx;
         my_ff   <= ok_y ? (in_my | bit_mask) : in_my;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_s     = s_ff;
   assign out_rx    = rx_ff;
   assign out_ry    = ry_ff;
   assign out_px    = px_ff;
   assign out_py    = py_ff;
   assign out_qx    = qx_ff;
   assign out_qy    = qy_ff;
   assign out_mx    = mx_ff;
   assign out_my    = my_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/core/view_frame_matrix_2d.sv =====
// Throughput: one item per cycle while not stalled; a chain of 15 search cells,
// one per bit of the unit magnitude, plus a square stage, a product stage and an
// output stage.
// The whole pipeline holds while a result waits and rsp_ready is low.
// Reset (synchronous) clears all valid bits; no clearing pass.
// Depends on vfm_pkg and vfm_cell.
module view_frame_matrix_2d
   import vfm_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_up_x,
   input  logic signed [COORD_WIDTH-1:0] req_up_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ROT_W-1:0]       rsp_row1_col1,
   output logic signed [ROT_W-1:0]       rsp_row1_col2,
   output logic signed [TRN_W-1:0]       rsp_row1_col3,
   output logic signed [ROT_W-1:0]       rsp_row2_col1,
   output logic signed [ROT_W-1:0]       rsp_row2_col2,
   output logic signed [TRN_W-1:0]       rsp_row2_col3,
   output logic                          rsp_zero_vector
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W + 34;
   localparam int SW = 2 * W + 3;
   localparam int MW = W + ROT_W + 1;
   localparam int TW = W + ROT_W + 3;

   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   // Square stage.
   logic signed [W:0]    vx_e, vy_e, ax, ay;
   logic                 a_valid_ff;
   logic [2*W+1:0]       ax2_ff, ay2_ff;
   logic [SW-1:0]        a_side_ff;

   assign vx_e = {req_up_x[W-1], req_up_x};
   assign vy_e = {req_up_y[W-1], req_up_y};
   assign ax   = vx_e[W] ? -vx_e : vx_e;
   assign ay   = vy_e[W] ? -vy_e : vy_e;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax2_ff    <= (2*W+2)'($unsigned(ax) * $unsigned(ax));
         ay2_ff    <= (2*W+2)'($unsigned(ay) * $unsigned(ay));
         a_side_ff <= {(req_up_x == '0) && (req_up_y == '0), req_up_x[W-1],
                       req_up_y[W-1], req_origin_x, req_origin_y};
      end
   end

   // Search chain.
   logic                 c_valid [Q_BITS+1];
   logic signed [PW-1:0] c_s  [Q_BITS+1];
   logic signed [PW-1:0] c_rx [Q_BITS+1];
   logic signed [PW-1:0] c_ry [Q_BITS+1];
   logic signed [PW-1:0] c_px [Q_BITS+1];
   logic signed [PW-1:0] c_py [Q_BITS+1];
   logic signed [PW-1:0] c_qx [Q_BITS+1];
   logic signed [PW-1:0] c_qy [Q_BITS+1];
   logic [Q_BITS-1:0]    c_mx [Q_BITS+1];
   logic [Q_BITS-1:0]    c_my [Q_BITS+1];
   logic [SW-1:0]        c_side [Q_BITS+1];

   // The bound compares (2m-1)^2*s against a^2*2^30; search starts at m = 0.
   assign c_valid[0] = a_valid_ff;
   assign c_s[0]     = $signed(PW'(ax2_ff)) + $signed(PW'(ay2_ff));
   assign c_rx[0]    = $signed(PW'(ax2_ff)) <<< (2 * FRAC_BITS + 2);
   assign c_ry[0]    = $signed(PW'(ay2_ff)) <<< (2 * FRAC_BITS + 2);
   assign c_px[0]    = c_s[0];
   assign c_py[0]    = c_s[0];
   assign c_qx[0]    = -c_s[0];
   assign c_qy[0]    = -c_s[0];
   assign c_mx[0]    = '0;
   assign c_my[0]    = '0;
   assign c_side[0]  = a_side_ff;

   for (genvar i = 0; i < Q_BITS; i++) begin : g_cell
      vfm_cell #(.PW(PW), .SW(SW), .BIT(Q_BITS - 1 - i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_valid (c_valid[i]),
         .in_s     (c_s[i]),
         .in_rx    (c_rx[i]),
         .in_ry    (c_ry[i]),
         .in_px    (c_px[i]),
         .in_py    (c_py[i]),
         .in_qx    (c_qx[i]),
         .in_qy    (c_qy[i]),
         .in_mx    (c_mx[i]),
         .in_my    (c_my[i]),
         .in_side  (c_side[i]),
         .out_valid(c_valid[i+1]),
         .out_s    (c_s[i+1]),
         .out_rx   (c_rx[i+1]),
         .out_ry   (c_ry[i+1]),
         .out_px   (c_px[i+1]),
         .out_py   (c_py[i+1]),
         .out_qx   (c_qx[i+1]),
         .out_qy   (c_qy[i+1]),
         .out_mx   (c_mx[i+1]),
         .out_my   (c_my[i+1]),
         .out_side (c_side[i+1])
      );
   end

   // Product stage.
   logic [SW-1:0]           e_side;
   logic                    e_zero, e_sx, e_sy;
   logic signed [W-1:0]     e_ox, e_oy;
   logic signed [ROT_W-1:0] mag_x, mag_y, nx, ny, ux;
   logic                    m_valid_ff, m_zero_ff;
   logic signed [ROT_W-1:0] m_nx_ff, m_ny_ff;
   logic signed [MW-1:0]    m_p1x_ff, m_p1y_ff, m_p2x_ff, m_p2y_ff;

   assign e_side = c_side[Q_BITS];
   assign {e_zero, e_sx, e_sy, e_ox, e_oy} = e_side;
   assign mag_x = $signed(ROT_W'(c_mx[Q_BITS]));
   assign mag_y = $signed(ROT_W'(c_my[Q_BITS]));
   assign nx    = e_zero ? '0 : (e_sx ? -mag_x : mag_x);
   assign ny    = e_zero ? '0 : (e_sy ? -mag_y : mag_y);
   assign ux    = -ny;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= c_valid[Q_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_zero_ff <= e_zero;
         m_nx_ff   <= nx;
         m_ny_ff   <= ny;
         m_p1x_ff  <= MW'(MW'(e_ox) * MW'(ux));
         m_p1y_ff  <= MW'(MW'(e_oy) * MW'(nx));
         m_p2x_ff  <= MW'(MW'(e_ox) * MW'(nx));
         m_p2y_ff  <= MW'(MW'(e_oy) * MW'(ny));
      end
   end

   // Negate the dot product, round to nearest (ties away) and saturate.
   function automatic logic signed [TRN_W-1:0] trans(input logic signed [MW-1:0] a,
                                                     input logic signed [MW-1:0] b);
      logic signed [TW-1:0] neg;
      logic [TW-1:0]        mag;
      logic [TW-1:0]        r;
      logic [TRN_W-1:0]     rs;
      neg = -(TW'(a) + TW'(b));
      mag = neg[TW-1] ? TW'(-neg) : TW'(neg);
      r   = (mag + TW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      rs  = (r > TW'(T_LIMIT)) ? TRN_W'(T_LIMIT) : TRN_W'(r);
      return neg[TW-1] ? -$signed(rs) : $signed(rs);
   endfunction

   logic                    o_valid_ff, o_zero_ff;
   logic signed [ROT_W-1:0] o_nx_ff, o_ny_ff;
   logic signed [TRN_W-1:0] o_t1_ff, o_t2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_zero_ff <= m_zero_ff;
         o_nx_ff   <= m_nx_ff;
         o_ny_ff   <= m_ny_ff;
         o_t1_ff   <= m_zero_ff ? '0 : trans(m_p1x_ff, m_p1y_ff);
         o_t2_ff   <= m_zero_ff ? '0 : trans(m_p2x_ff, m_p2y_ff);
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_row1_col1   = -o_ny_ff;
   assign rsp_row1_col2   = o_nx_ff;
   assign rsp_row1_col3   = o_t1_ff;
   assign rsp_row2_col1   = o_nx_ff;
   assign rsp_row2_col2   = o_ny_ff;
   assign rsp_row2_col3   = o_t2_ff;
   assign rsp_zero_vector = o_zero_ff;

endmodule

// ===== rtl/core/vfm_checker.sv =====
// Port-level checks for view_frame_matrix_2d, attached with bind.
// Depends on vfm_pkg for field widths.
module vfm_checker
   import vfm_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [ROT_W-1:0] rsp_row1_col1,
   input logic signed [ROT_W-1:0] rsp_row1_col2,
   input logic signed [TRN_W-1:0] rsp_row1_col3,
   input logic signed [ROT_W-1:0] rsp_row2_col1,
   input logic signed [ROT_W-1:0] rsp_row2_col2,
   input logic signed [TRN_W-1:0] rsp_row2_col3,
   input logic                    rsp_zero_vector
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item shown right after reset");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_vector |-> rsp_row1_col1 == '0 && rsp_row1_col2 == '0 &&
      rsp_row1_col3 == '0 && rsp_row2_col2 == '0 && rsp_row2_col3 == '0)
      else $error("zero vector item carries nonzero fields");

   a_shared_nx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row1_col2 == rsp_row2_col1)
      else $error("u_y and v_x differ");

   a_perp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ROT_W'(rsp_row1_col1 + rsp_row2_col2) == '0)
      else $error("u_x is not the negated v_y");

endmodule

bind view_frame_matrix_2d vfm_checker u_vfm_checker (.*);

// ===== tb/tb_view_frame_matrix_2d.sv =====
// Testbench for view_frame_matrix_2d: random and corner origin/up items, a matrix
// predictor written in SystemVerilog and a small scoreboard that checks each result.
// Depends on vfm_pkg and the view_frame_matrix_2d RTL.
module tb_view_frame_matrix_2d
   import vfm_pkg::*;
;

   typedef struct {
      logic signed [ROT_W-1:0] r1c1, r1c2, r2c1, r2c2;
      logic signed [TRN_W-1:0] r1c3, r2c3;
      logic                    zero;
   } matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_origin_x = '0, req_origin_y = '0, req_up_x = '0, req_up_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [ROT_W-1:0] rsp_row1_col1, rsp_row1_col2, rsp_row2_col1, rsp_row2_col2;
   logic signed [TRN_W-1:0] rsp_row1_col3, rsp_row2_col3;
   logic rsp_zero_vector;

   int  errors = 0;
   bit  idle_free = 1'b0;
   bit  hold_rsp = 1'b0;

   always #1 clock = ~clock;

   view_frame_matrix_2d u_dut (.*);

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // Rounded magnitude of a * 2^14 / sqrt(s), found by search on exact squares.
   function automatic longint unit_mag(input longint a, input longint s);
      longint lo, hi, mid, d;
      logic [127:0] rhs, lhs;
      lo = 0;
      hi = 16384;
      rhs = 128'(a * a) << 30;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         d = 2 * mid - 1;
         lhs = 128'(d * d) * 128'(s);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic longint translate(input longint px, py, cx, cy);
      longint neg, mag, r;
      neg = -(px * cx + py * cy);
      mag = neg < 0 ? -neg : neg;
      r = (mag + 8192) >>> 14;
      if (r > T_LIMIT) r = T_LIMIT;
      return neg < 0 ? -r : r;
   endfunction

   function automatic matrix_type view_matrix(input logic signed [15:0] px, py, vx, vy);
      matrix_type m;
      longint ax, ay, s, nx, ny;
      m = '{default: '0};
      if (vx == 0 && vy == 0) begin
         m.zero = 1'b1;
         return m;
      end
      ax = vx < 0 ? -longint'(vx) : longint'(vx);
      ay = vy < 0 ? -longint'(vy) : longint'(vy);
      s = ax * ax + ay * ay;
      nx = unit_mag(ax, s);
      ny = unit_mag(ay, s);
      if (vx < 0) nx = -nx;
      if (vy < 0) ny = -ny;
      m.r1c1 = ROT_W'(-ny);
      m.r1c2 = ROT_W'(nx);
      m.r2c1 = ROT_W'(nx);
      m.r2c2 = ROT_W'(ny);
      m.r1c3 = TRN_W'(translate(px, py, -ny, nx));
      m.r2c3 = TRN_W'(translate(px, py, nx, ny));
      return m;
   endfunction

   class matrix_board;
      matrix_type pending[$];

      function void note_item(logic signed [15:0] px, py, vx, vy);
         pending.push_back(view_matrix(px, py, vx, vy));
      endfunction

      task check_result(matrix_type got);
         matrix_type want;
         if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         want = pending.pop_front();
         if (got.r1c1 !== want.r1c1) report("row1_col1", got.r1c1, want.r1c1);
         if (got.r1c2 !== want.r1c2) report("row1_col2", got.r1c2, want.r1c2);
         if (got.r1c3 !== want.r1c3) report("row1_col3", got.r1c3, want.r1c3);
         if (got.r2c1 !== want.r2c1) report("row2_col1", got.r2c1, want.r2c1);
         if (got.r2c2 !== want.r2c2) report("row2_col2", got.r2c2, want.r2c2);
         if (got.r2c3 !== want.r2c3) report("row2_col3", got.r2c3, want.r2c3);
         if (got.zero !== want.zero) report("zero_vector", got.zero, want.zero);
      endtask
   endclass

   matrix_board board = new();

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 16)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   // Sends one item; valid stays high across back-to-back items.
   task automatic send_item(input logic [15:0] px, py, vx, vy);
      while (!idle_free && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_origin_x <= px;
      req_origin_y <= py;
      req_up_x <= vx;
      req_up_y <= vy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(px, py, vx, vy);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Result side: random stalls, plus a long hold-off when asked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result('{rsp_row1_col1, rsp_row1_col2, rsp_row2_col1, rsp_row2_col2,
                              rsp_row1_col3, rsp_row2_col3, rsp_zero_vector});
      rsp_ready <= !hold_rsp && (idle_free || $urandom_range(0, 99) >= 7);
   end

   initial begin
      logic [15:0] ext [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: zero vector, axis vectors, extremes and saturation of translation.
      send_item(16'h1234, 16'h8000, 16'h0000, 16'h0000);
      for (int i = 0; i < 6; i++)
         send_item(ext[i], ext[5 - i], ext[(i + 1) % 6], ext[(i + 3) % 6]);
      send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_item(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_item(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF);
      send_item(16'h0000, 16'h0000, 16'h0000, 16'h0300);
      send_item(16'h0100, 16'hFF00, 16'hFD00, 16'h0000);
      send_item(16'h0000, 16'h0000, 16'h0003, 16'h0004);
      drain();
      // The receiver holds off while items keep coming, so the pipeline stalls.
      hold_rsp = 1'b1;
      fork
         begin repeat (200) @(posedge clock); hold_rsp = 1'b0; end
         for (int i = 0; i < 60; i++)
            send_item(16'($urandom), 16'($urandom), rand_coord(), rand_coord());
      join
      drain();
      for (int i = 0; i < 1000; i++) begin
         idle_free = (i >= 400 && i < 600);
         send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      idle_free = 1'b0;
      drain();
      repeat (40) @(posedge clock);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #200000;
      $display("TB_ERROR");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/vfm_pkg.sv
rtl/core/vfm_cell.sv
rtl/core/view_frame_matrix_2d.sv
rtl/core/vfm_checker.sv
tb/tb_view_frame_matrix_2d.sv
